FILE: design/dwpp_pkg.sv
package dwpp_pkg;

    // Duty resolution and clamp limit.
    localparam int DUTY_BITS = 10;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    // Internal word widths of one wheel lane.
    localparam int GAIN_W = 16;
    localparam int TGT_W  = 16;
    localparam int MEAS_W = 15;
    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int SUM_W  = 32;
    localparam int PP_W   = GAIN_W + 1 + ERR_W;
    localparam int PI_W   = GAIN_W + 1 + SUM_W;
    localparam int PD_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = PI_W + 1;
    localparam int FRAC_W = 16;
    localparam int CORR_W = ACC_W - FRAC_W;
    localparam int IDX_W  = 3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    // Gain reset values, unsigned Q0.16.
    localparam logic [GAIN_W-1:0] LEFT_PROP_RST   = 16'd1065;
    localparam logic [GAIN_W-1:0] LEFT_INTEG_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] LEFT_DERIV_RST  = 16'd6881;
    localparam logic [GAIN_W-1:0] RIGHT_PROP_RST  = 16'd1065;
    localparam logic [GAIN_W-1:0] RIGHT_INTEG_RST = 16'd0;
    localparam logic [GAIN_W-1:0] RIGHT_DERIV_RST = 16'd6758;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_LEFT_PROP   = 3'd0,
        REG_LEFT_INTEG  = 3'd1,
        REG_LEFT_DERIV  = 3'd2,
        REG_RIGHT_PROP  = 3'd3,
        REG_RIGHT_INTEG = 3'd4,
        REG_RIGHT_DERIV = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_left_speed;
        logic signed [TGT_W-1:0] target_right_speed;
        logic [MEAS_W-1:0]       measured_left_speed;
        logic [MEAS_W-1:0]       measured_right_speed;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_duty;
        logic [DUTY_BITS-1:0] right_duty;
        logic                 left_reverse;
        logic                 right_reverse;
    } out_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gain_set_t;

    // Pipeline control shared by both lanes.
    typedef struct packed {
        logic advance;     // all stages move one step
        logic load;        // a word is taken into the first stage
        logic calc_valid;  // the correction stage holds a live word
    } pipe_ctrl_t;

endpackage

FILE: design/dwpp_lane.sv
module dwpp_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dwpp_pkg::pipe_ctrl_t                  ctrl,
    input  dwpp_pkg::gain_set_t                   gains,
    input  logic signed [dwpp_pkg::TGT_W-1:0]     target,
    input  logic [dwpp_pkg::MEAS_W-1:0]           measured,
    output logic [dwpp_pkg::DUTY_BITS-1:0]        duty,
    output logic                                  reverse
);

    localparam int ERR_W  = dwpp_pkg::ERR_W;
    localparam int DIFF_W = dwpp_pkg::DIFF_W;
    localparam int SUM_W  = dwpp_pkg::SUM_W;
    localparam int ACC_W  = dwpp_pkg::ACC_W;
    localparam int CORR_W = dwpp_pkg::CORR_W;
    localparam int DUTY_BITS = dwpp_pkg::DUTY_BITS;
    localparam int ND_W   = CORR_W + 1;

    // Controller state.
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [ERR_W-1:0]  prev_reg;
    logic [DUTY_BITS-1:0]     duty_reg, duty_next;
    logic                     rev_reg;

    // Stage registers.
    logic signed [ERR_W-1:0]          err_s1_reg;
    logic signed [SUM_W-1:0]          sum_s1_reg;
    logic signed [DIFF_W-1:0]         diff_s1_reg;
    logic                             rev_s1_reg;
    logic signed [dwpp_pkg::PP_W-1:0] pp_s2_reg;
    logic signed [dwpp_pkg::PI_W-1:0] pi_s2_reg;
    logic signed [dwpp_pkg::PD_W-1:0] pd_s2_reg;
    logic                             rev_s2_reg;
    logic signed [CORR_W-1:0]         corr_s3_reg;
    logic                             rev_s3_reg;

    logic signed [ERR_W-1:0]    tgt_ext, mag, err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [ERR_W-1:0]    kp_s, ki_s, kd_s;
    logic signed [dwpp_pkg::PP_W-1:0] pp;
    logic signed [dwpp_pkg::PI_W-1:0] pi;
    logic signed [dwpp_pkg::PD_W-1:0] pd;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ND_W-1:0]     nd;

    // Stage one: direction, magnitude, error and the saturating integral.
    always_comb begin
        tgt_ext  = {target[dwpp_pkg::TGT_W-1], target};
        mag      = target[dwpp_pkg::TGT_W-1] ? -tgt_ext : tgt_ext;
        err      = mag - $signed({2'b00, measured});
        diff     = $signed({err[ERR_W-1], err}) - $signed({prev_reg[ERR_W-1], prev_reg});
        sum_wide = $signed({sum_reg[SUM_W-1], sum_reg})
                 + $signed({{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? dwpp_pkg::SUM_MIN : dwpp_pkg::SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // Stage two: one multiplier per PID term.
    always_comb begin
        kp_s = $signed({1'b0, gains.prop});
        ki_s = $signed({1'b0, gains.integ});
        kd_s = $signed({1'b0, gains.deriv});
        pp   = kp_s * err_s1_reg;
        pi   = ki_s * sum_s1_reg;
        pd   = kd_s * diff_s1_reg;
    end

    // Stage three: sum of the terms, rounded half up, floor shift.
    always_comb begin
        acc = ACC_W'(pp_s2_reg) + ACC_W'(pi_s2_reg) + ACC_W'(pd_s2_reg)
            + dwpp_pkg::ROUND_HALF;
    end

    // Stage four: duty update with clamping.
    always_comb begin
        nd = $signed({{(ND_W-DUTY_BITS){1'b0}}, duty_reg})
           + $signed({corr_s3_reg[CORR_W-1], corr_s3_reg});
        if (nd[ND_W-1]) begin
            duty_next = '0;
        end else if (nd > $signed({{(ND_W-DUTY_BITS){1'b0}}, dwpp_pkg::DUTY_MAX})) begin
            duty_next = dwpp_pkg::DUTY_MAX;
        end else begin
            duty_next = nd[DUTY_BITS-1:0];
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            prev_reg <= '0;
            duty_reg <= '0;
            rev_reg  <= 1'b0;
        end else begin
            if (ctrl.load) begin
                sum_reg  <= sum_next;
                prev_reg <= err;
            end
            if (ctrl.advance && ctrl.calc_valid) begin
                duty_reg <= duty_next;
                rev_reg  <= rev_s3_reg;
            end
        end
    end

    // Data stages move together.
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            err_s1_reg  <= err;
            sum_s1_reg  <= sum_reg;
            diff_s1_reg <= diff;
            rev_s1_reg  <= target[dwpp_pkg::TGT_W-1];
            pp_s2_reg   <= pp;
            pi_s2_reg   <= pi;
            pd_s2_reg   <= pd;
            rev_s2_reg  <= rev_s1_reg;
            corr_s3_reg <= acc[ACC_W-1:dwpp_pkg::FRAC_W];
            rev_s3_reg  <= rev_s2_reg;
        end
    end

    assign duty    = duty_reg;
    assign reverse = rev_reg;

    // The integral and previous error move only when a word is taken.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.load |=> ($stable(sum_reg) && $stable(prev_reg)))
        else $error("lane state changed without a new word");

    // The stored duty moves only when a live correction leaves stage three.
    a_duty_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.advance && ctrl.calc_valid) |=> $stable(duty_reg))
        else $error("duty changed without a correction");

endmodule

FILE: design/dual_wheel_pid_pwm.sv
// An accepted word passes through stages one to four of each lane, then appears on m_data.
// Throughput: one word per cycle; the four-stage lane pipeline stalls as a whole
// only while a finished word waits on m_ready.
// Reset (aresetn low, synchronous): integrals, previous errors and duties clear
// to zero, gains return to their defaults, and the pipeline empties.
module dual_wheel_pid_pwm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dwpp_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dwpp_pkg::out_word_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [dwpp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [dwpp_pkg::GAIN_W-1:0]   cfg_wr_data
);

    dwpp_pkg::gain_set_t  left_gains_reg, right_gains_reg;
    dwpp_pkg::pipe_ctrl_t ctrl;
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic advance;

    logic [dwpp_pkg::DUTY_BITS-1:0] left_duty, right_duty;
    logic                           left_rev, right_rev;

    // Gain registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_gains_reg  <= '{dwpp_pkg::LEFT_PROP_RST, dwpp_pkg::LEFT_INTEG_RST,
                                 dwpp_pkg::LEFT_DERIV_RST};
            right_gains_reg <= '{dwpp_pkg::RIGHT_PROP_RST, dwpp_pkg::RIGHT_INTEG_RST,
                                 dwpp_pkg::RIGHT_DERIV_RST};
        end else if (cfg_wr_en) begin
            case (dwpp_pkg::cfg_reg_t'(cfg_index))
                dwpp_pkg::REG_LEFT_PROP:   left_gains_reg.prop   <= cfg_wr_data;
                dwpp_pkg::REG_LEFT_INTEG:  left_gains_reg.integ  <= cfg_wr_data;
                dwpp_pkg::REG_LEFT_DERIV:  left_gains_reg.deriv  <= cfg_wr_data;
                dwpp_pkg::REG_RIGHT_PROP:  right_gains_reg.prop  <= cfg_wr_data;
                dwpp_pkg::REG_RIGHT_INTEG: right_gains_reg.integ <= cfg_wr_data;
                dwpp_pkg::REG_RIGHT_DERIV: right_gains_reg.deriv <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Pipeline moves whenever the output register is free or being emptied.
    assign advance         = !m_valid_reg || m_ready;
    assign s_ready         = advance;
    assign ctrl.advance    = advance;
    assign ctrl.load       = s_valid && advance;
    assign ctrl.calc_valid = v3_reg;

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    // One lane per wheel.
    dwpp_lane u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .gains    (left_gains_reg),
        .target   (s_data.target_left_speed),
        .measured (s_data.measured_left_speed),
        .duty     (left_duty),
        .reverse  (left_rev)
    );

    dwpp_lane u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .gains    (right_gains_reg),
        .target   (s_data.target_right_speed),
        .measured (s_data.measured_right_speed),
        .duty     (right_duty),
        .reverse  (right_rev)
    );

    // Merge both lanes into the result word.
    always_comb begin
        m_data.left_duty     = left_duty;
        m_data.right_duty    = right_duty;
        m_data.left_reverse  = left_rev;
        m_data.right_reverse = right_rev;
    end

    assign m_valid = m_valid_reg;

    // A word taken into an unstalled pipeline reaches the output.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 s_ready ##1 s_ready ##1 s_ready |=> m_valid)
        else $error("result word did not arrive on time");

    // Without any word in flight, no result word can appear.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !m_valid_reg) |=> !m_valid)
        else $error("result word appeared with an empty pipeline");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import dwpp_pkg::*;

    localparam int PIPE_DEPTH   = 4;
    localparam int GAP_MAX      = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 205;
    localparam int WHEEL_L      = 0;
    localparam int WHEEL_R      = 1;
    localparam int SPEED_MIN    = -32768;
    localparam int SPEED_MAX    = 32767;
    localparam int MEAS_TOP     = 32767;

    // Gain of one sixteenth in unsigned Q0.16.
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

    // Register indexes past the last gain; writes to them must be dropped.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam out_word_t DUTY_LOW       = '0;
    localparam out_word_t DUTY_HIGH      = '{DUTY_MAX, DUTY_MAX, 1'b0, 1'b0};
    localparam out_word_t DUTY_HIGH_BACK = '{DUTY_MAX, DUTY_MAX, 1'b1, 1'b1};

    typedef enum logic {
        ROW_TICK,
        ROW_GAIN
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [GAIN_W-1:0] gain;
        in_word_t          word;
        logic              typed;
        out_word_t         result;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_word_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_word_t           m_data;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [GAIN_W-1:0]   cfg_wr_data;

    // Shadow copy of the gains and of each wheel's loop state.
    logic [GAIN_W-1:0]        prop_gain [2];
    logic [GAIN_W-1:0]        integ_gain [2];
    logic [GAIN_W-1:0]        deriv_gain [2];
    logic signed [SUM_W-1:0]  err_sum [2];
    logic signed [ERR_W-1:0]  last_err [2];
    logic [DUTY_BITS-1:0]     duty_reg [2];

    out_word_t pending_duty [$];
    out_word_t want;
    int        failures = 0;
    int        tx_gap_max = GAP_MAX;
    int        rx_gap_max = GAP_MAX;

    dual_wheel_pid_pwm dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // One wheel for one control tick: PID correction, duty clamp, then the
    // saturating integral and the previous error move on.
    function automatic logic [DUTY_BITS-1:0] wheel_tick(input int w,
                                                        input logic signed [TGT_W-1:0] target,
                                                        input logic [MEAS_W-1:0] meas);
        logic signed [ERR_W-1:0] mag;
        logic signed [ERR_W-1:0] err;
        longint acc;
        longint corr;
        longint duty_next;
        longint sum_next;
        mag = ERR_W'(target);
        if (target < 0) begin
            mag = -mag;
        end
        err = mag - $signed({2'b00, meas});
        acc = longint'(prop_gain[w]) * longint'(err)
            + longint'(integ_gain[w]) * longint'(err_sum[w])
            + longint'(deriv_gain[w]) * (longint'(err) - longint'(last_err[w]));
        // Round to nearest with ties upward, then drop the 16 fraction bits.
        corr = (acc + 64'sd32768) >>> FRAC_W;
        duty_next = longint'(duty_reg[w]) + corr;
        if (duty_next < 0) begin
            duty_next = 0;
        end else if (duty_next > longint'(DUTY_MAX)) begin
            duty_next = longint'(DUTY_MAX);
        end
        sum_next = longint'(err_sum[w]) + longint'(err);
        if (sum_next > longint'(SUM_MAX)) begin
            sum_next = longint'(SUM_MAX);
        end else if (sum_next < longint'(SUM_MIN)) begin
            sum_next = longint'(SUM_MIN);
        end
        duty_reg[w] = duty_next[DUTY_BITS-1:0];
        err_sum[w]  = sum_next[SUM_W-1:0];
        last_err[w] = err;
        return duty_reg[w];
    endfunction

    function automatic out_word_t pid_tick(input in_word_t w);
        out_word_t r;
        r.left_duty     = wheel_tick(WHEEL_L, w.target_left_speed, w.measured_left_speed);
        r.right_duty    = wheel_tick(WHEEL_R, w.target_right_speed, w.measured_right_speed);
        r.left_reverse  = w.target_left_speed[TGT_W-1];
        r.right_reverse = w.target_right_speed[TGT_W-1];
        return r;
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic signed [TGT_W-1:0] near_target(input int aim);
        return TGT_W'(clip(aim + int'($urandom_range(0, 64)) - 32, SPEED_MIN, SPEED_MAX));
    endfunction

    // A measured speed that follows the target's magnitude with some noise.
    function automatic logic [MEAS_W-1:0] near_meas(input logic signed [TGT_W-1:0] target);
        int mag;
        mag = (target < 0) ? -int'(target) : int'(target);
        return MEAS_W'(clip(mag + int'($urandom_range(0, 96)) - 48, 0, MEAS_TOP));
    endfunction

    function automatic logic signed [TGT_W-1:0] rail_target();
        case ($urandom_range(0, 4))
            0: return TGT_W'(SPEED_MIN);
            1: return -TGT_W'(1);
            2: return '0;
            3: return TGT_W'(1);
            default: return TGT_W'(SPEED_MAX);
        endcase
    endfunction

    // Mostly tracking words around the current aims, some noise and rails.
    function automatic in_word_t random_word(input int aim_l, input int aim_r);
        in_word_t w;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            w.target_left_speed    = TGT_W'($urandom);
            w.target_right_speed   = TGT_W'($urandom);
            w.measured_left_speed  = MEAS_W'($urandom);
            w.measured_right_speed = MEAS_W'($urandom);
        end else if (pick == 2) begin
            w.target_left_speed    = rail_target();
            w.target_right_speed   = rail_target();
            w.measured_left_speed  = $urandom_range(0, 1) ? MEAS_W'(MEAS_TOP) : '0;
            w.measured_right_speed = $urandom_range(0, 1) ? MEAS_W'(MEAS_TOP) : '0;
        end else begin
            w.target_left_speed    = near_target(aim_l);
            w.target_right_speed   = near_target(aim_r);
            w.measured_left_speed  = near_meas(w.target_left_speed);
            w.measured_right_speed = near_meas(w.target_right_speed);
        end
        return w;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom_range(0, 255));
            3, 4: return GAIN_W'($urandom_range(0, 4095));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic plan_row_t tick_row(input int tl, input int tr, input int ml,
                                           input int mr, input logic typed,
                                           input out_word_t res);
        plan_row_t row;
        row = '0;
        row.kind = ROW_TICK;
        row.word.target_left_speed    = TGT_W'(tl);
        row.word.target_right_speed   = TGT_W'(tr);
        row.word.measured_left_speed  = MEAS_W'(ml);
        row.word.measured_right_speed = MEAS_W'(mr);
        row.typed  = typed;
        row.result = res;
        return row;
    endfunction

    function automatic plan_row_t gain_row(input logic [IDX_W-1:0] idx,
                                           input logic [GAIN_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind = ROW_GAIN;
        row.idx  = idx;
        row.gain = val;
        return row;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
            failures++;
        end
    endtask

    // Offer one word after a random gap and predict its result on acceptance.
    task automatic push_word(input in_word_t w, input logic typed, input out_word_t typed_res);
        int gap;
        out_word_t predicted;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = pid_tick(w);
        pending_duty.push_back(typed ? typed_res : predicted);
    endtask

    // Stop sending and let every outstanding word drain out of the pipeline.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_duty.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic set_gain(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (cfg_reg_t'(idx))
            REG_LEFT_PROP:   prop_gain[WHEEL_L]  = val;
            REG_LEFT_INTEG:  integ_gain[WHEEL_L] = val;
            REG_LEFT_DERIV:  deriv_gain[WHEEL_L] = val;
            REG_RIGHT_PROP:  prop_gain[WHEEL_R]  = val;
            REG_RIGHT_INTEG: integ_gain[WHEEL_R] = val;
            REG_RIGHT_DERIV: deriv_gain[WHEEL_R] = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: stall for a random number of cycles before each word.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            stall = $urandom_range(0, rx_gap_max);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_valid);
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_duty.size() == 0) begin
                $display("%0t: expected no word, got %p", $time, m_data);
                failures++;
            end else begin
                want = pending_duty.pop_front();
                check_field("left_duty", want.left_duty, m_data.left_duty);
                check_field("right_duty", want.right_duty, m_data.right_duty);
                check_field("left_reverse", want.left_reverse, m_data.left_reverse);
                check_field("right_reverse", want.right_reverse, m_data.right_reverse);
            end
        end
    end

    initial begin : stimulus
        plan_row_t plan [$];
        int aim_l;
        int aim_r;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        prop_gain[WHEEL_L]  = LEFT_PROP_RST;
        integ_gain[WHEEL_L] = LEFT_INTEG_RST;
        deriv_gain[WHEEL_L] = LEFT_DERIV_RST;
        prop_gain[WHEEL_R]  = RIGHT_PROP_RST;
        integ_gain[WHEEL_R] = RIGHT_INTEG_RST;
        deriv_gain[WHEEL_R] = RIGHT_DERIV_RST;
        for (int i = 0; i < 2; i++) begin
            err_sum[i]  = '0;
            last_err[i] = '0;
            duty_reg[i] = '0;
        end

        // Directed words under the reset gains: zero error holds zero duty,
        // full-scale errors drive both duties onto their rails.
        plan.push_back(tick_row(0, 0, 0, 0, 1'b1, DUTY_LOW));
        plan.push_back(tick_row(SPEED_MAX, SPEED_MAX, 0, 0, 1'b1, DUTY_HIGH));
        plan.push_back(tick_row(SPEED_MIN, SPEED_MIN, 0, 0, 1'b1, DUTY_HIGH_BACK));
        plan.push_back(tick_row(0, 0, MEAS_TOP, MEAS_TOP, 1'b1, DUTY_LOW));
        plan.push_back(tick_row(-1, 1, 1, 0, 1'b0, DUTY_LOW));
        // Writes past the last register must leave every gain alone.
        plan.push_back(gain_row(REG_SPARE_LO, '1));
        plan.push_back(gain_row(REG_SPARE_HI, '0));
        plan.push_back(tick_row(1000, -1000, 990, 1010, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(1000, -1000, 1000, 1000, 1'b0, DUTY_LOW));
        // All gains zero: the duty must hold whatever the error.
        for (int r = REG_LEFT_PROP; r <= REG_RIGHT_DERIV; r++) begin
            plan.push_back(gain_row(IDX_W'(r), '0));
        end
        plan.push_back(tick_row(SPEED_MIN, SPEED_MAX, MEAS_TOP, 0, 1'b0, DUTY_LOW));
        // Proportional gain of one sixteenth: half-step errors show the rounding ties.
        plan.push_back(gain_row(REG_LEFT_PROP, GAIN_ONE));
        plan.push_back(gain_row(REG_RIGHT_PROP, GAIN_ONE));
        plan.push_back(tick_row(8, 0, 0, 8, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(7, 0, 0, 9, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(24, -24, 0, 0, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(-8, 8, 0, 24, 1'b0, DUTY_LOW));
        // Every gain at its maximum.
        for (int r = REG_LEFT_PROP; r <= REG_RIGHT_DERIV; r++) begin
            plan.push_back(gain_row(IDX_W'(r), '1));
        end
        plan.push_back(tick_row(SPEED_MAX, SPEED_MIN, 0, 0, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(0, 0, MEAS_TOP, MEAS_TOP, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(5, -5, 5, 5, 1'b0, DUTY_LOW));
        plan.push_back(tick_row(-5, 5, 0, 10, 1'b0, DUTY_LOW));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_GAIN) begin
                settle();
                set_gain(plan[i].idx, plan[i].gain);
            end else begin
                push_word(plan[i].word, plan[i].typed, plan[i].result);
            end
        end

        // Random phases, each with fresh gains and its own idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            for (int r = REG_LEFT_PROP; r <= REG_RIGHT_DERIV; r++) begin
                set_gain(IDX_W'(r), pick_gain());
            end
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            aim_l = int'($urandom_range(0, 65535)) - 32768;
            aim_r = int'($urandom_range(0, 65535)) - 32768;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Occasional step change of the speed set points.
                if ($urandom_range(0, 39) == 0) begin
                    aim_l = int'($urandom_range(0, 65535)) - 32768;
                    aim_r = int'($urandom_range(0, 65535)) - 32768;
                end
                push_word(random_word(aim_l, aim_r), 1'b0, DUTY_LOW);
            end
        end

        settle();
        if (failures == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("tb NOT OK");
        $finish;
    end

endmodule
